// File: rtl/core/itrd_pkg.sv
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types, constants, microcode program and helper functions of the
// integer to radix digits unit.
// ----------------------------------------------------------------------------
package itrd_pkg;

  // payload and register widths
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned SYM_WORD_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  // parameter defaults
  localparam int unsigned MAX_RADIX_DEF  = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_LO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_HI   = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // micro-operations
  typedef enum logic [2:0] {
    UOP_ACCEPT   = 3'd0,
    UOP_SIGN     = 3'd1,
    UOP_DIV_GO   = 3'd2,
    UOP_DIV_WAIT = 3'd3,
    UOP_POP      = 3'd4,
    UOP_EMIT     = 3'd5
  } uop_e;

  // jump conditions
  typedef enum logic [1:0] {
    COND_NONE     = 2'd0,
    COND_BASE_BAD = 2'd1,
    COND_QUOT_NZ  = 2'd2,
    COND_COUNT_NZ = 2'd3
  } cond_e;

  localparam int unsigned STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_ACCEPT   = 3'd0;
  localparam step_t STEP_SIGN     = 3'd1;
  localparam step_t STEP_DIV_GO   = 3'd2;
  localparam step_t STEP_DIV_WAIT = 3'd3;
  localparam step_t STEP_POP      = 3'd4;
  localparam step_t STEP_EMIT     = 3'd5;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    step_t jump;
    step_t next;
  } ucode_word_t;

  typedef struct packed {
    logic in_valid;
    logic base_ok;
    logic out_free;
    logic neg;
    logic div_done;
    logic quot_nz;
    logic count_nz;
  } seq_status_t;

  typedef struct packed {
    uop_e op;
    logic fire;
  } seq_ctrl_t;

  // control store
  function automatic ucode_word_t ucode_rom(step_t step);
    ucode_word_t w;
    case (step)
      STEP_ACCEPT:   w = '{UOP_ACCEPT,   COND_BASE_BAD, STEP_ACCEPT, STEP_SIGN};
      STEP_SIGN:     w = '{UOP_SIGN,     COND_NONE,     STEP_ACCEPT, STEP_DIV_GO};
      STEP_DIV_GO:   w = '{UOP_DIV_GO,   COND_NONE,     STEP_ACCEPT, STEP_DIV_WAIT};
      STEP_DIV_WAIT: w = '{UOP_DIV_WAIT, COND_QUOT_NZ,  STEP_DIV_GO, STEP_POP};
      STEP_POP:      w = '{UOP_POP,      COND_NONE,     STEP_ACCEPT, STEP_EMIT};
      STEP_EMIT:     w = '{UOP_EMIT,     COND_COUNT_NZ, STEP_POP,    STEP_ACCEPT};
      default:       w = '{UOP_ACCEPT,   COND_NONE,     STEP_ACCEPT, STEP_ACCEPT};
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] symbol_at(logic [SYM_WORD_W-1:0] lo,
                                                  logic [SYM_WORD_W-1:0] hi,
                                                  logic [3:0]            d);
    logic [SYM_WORD_W-1:0] word;
    word = d[3] ? hi : lo;
    return word[{d[2:0], 3'b000} +: CHAR_W];
  endfunction

  // radix range, no sign symbols, no repeated symbols among those in use
  function automatic logic base_ok(logic [LEN_W-1:0]      len,
                                   logic [SYM_WORD_W-1:0] lo,
                                   logic [SYM_WORD_W-1:0] hi,
                                   logic [LEN_W-1:0]      max_radix);
    logic          ok;
    logic [CHAR_W-1:0] si;
    ok = (len >= LEN_W'(2)) && (len <= max_radix) && (len <= LEN_W'(16));
    for (int i = 0; i < 16; i++) begin
      si = symbol_at(lo, hi, 4'(i));
      if (LEN_W'(i) < len) begin
        if (si == CHAR_PLUS || si == CHAR_MINUS) ok = 1'b0;
        for (int j = i + 1; j < 16; j++) begin
          if (LEN_W'(j) < len && symbol_at(lo, hi, 4'(j)) == si) ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

// File: rtl/core/itrd_intf.sv
// ----------------------------------------------------------------------------
// itrd channel interfaces
// Valid/ready channels for values in, characters out and register writes.
// ----------------------------------------------------------------------------
interface itrd_in_if;
  logic                         valid;
  logic                         ready;
  logic [itrd_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itrd_out_if;
  logic                        valid;
  logic                        ready;
  logic [itrd_pkg::CHAR_W-1:0] character;
  logic                        last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

interface itrd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [itrd_pkg::CFG_IDX_W-1:0]  index;
  logic [itrd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/itrd_ram.sv
// ----------------------------------------------------------------------------
// itrd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module itrd_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/itrd_divider.sv
// ----------------------------------------------------------------------------
// itrd_divider
// Restoring divider by a small radix, eight quotient bits per cycle.
// ----------------------------------------------------------------------------
module itrd_divider #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned RADIX_W    = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [RADIX_W-1:0]    divisor_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] quotient_o,
  output logic [RADIX_W-1:0]    remainder_o
);

  localparam int unsigned STEPS   = 8;
  localparam int unsigned DIV_CYC = (VALUE_BITS + STEPS - 1) / STEPS;
  localparam int unsigned DIV_W   = DIV_CYC * STEPS;
  localparam int unsigned CYC_W   = $clog2(DIV_CYC + 1);

  logic [DIV_W-1:0]   work_q, work_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] divisor_q;
  logic [CYC_W-1:0]   iter_q;
  logic               busy_q;
  logic               done_q;
  logic [RADIX_W:0]   trial;

  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    trial  = '0;
    for (int s = 0; s < STEPS; s++) begin
      trial  = {rem_d, work_d[DIV_W-1]};
      work_d = {work_d[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_q}) begin
        trial     = trial - {1'b0, divisor_q};
        work_d[0] = 1'b1;
      end
      rem_d = trial[RADIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      iter_q <= CYC_W'(DIV_CYC);
    end else if (busy_q) begin
      iter_q <= iter_q - CYC_W'(1);
      if (iter_q == CYC_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q    <= DIV_W'(dividend_i);
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = work_q[VALUE_BITS-1:0];
  assign remainder_o = rem_q;

endmodule

// File: rtl/core/itrd_sequencer.sv
// ----------------------------------------------------------------------------
// itrd_sequencer
// Step counter and control store; picks the next step from the current
// control word and the datapath status.
// ----------------------------------------------------------------------------
module itrd_sequencer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  itrd_pkg::seq_status_t status_i,
  output itrd_pkg::seq_ctrl_t   ctrl_o
);

  import itrd_pkg::*;

  step_t       step_q, step_d;
  ucode_word_t word;
  logic        fire;
  logic        cond_true;

  assign word = ucode_rom(step_q);

  // a step completes once the resource it needs is available
  always_comb begin
    case (word.op)
      UOP_ACCEPT:   fire = status_i.in_valid;
      UOP_SIGN:     fire = !status_i.neg || status_i.out_free;
      UOP_DIV_GO:   fire = 1'b1;
      UOP_DIV_WAIT: fire = status_i.div_done;
      UOP_POP:      fire = 1'b1;
      UOP_EMIT:     fire = status_i.out_free;
      default:      fire = 1'b0;
    endcase
  end

  always_comb begin
    case (word.cond)
      COND_NONE:     cond_true = 1'b0;
      COND_BASE_BAD: cond_true = !status_i.base_ok;
      COND_QUOT_NZ:  cond_true = status_i.quot_nz;
      COND_COUNT_NZ: cond_true = status_i.count_nz;
      default:       cond_true = 1'b0;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (fire) begin
      step_d = cond_true ? word.jump : word.next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_ACCEPT;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o.op   = word.op;
  assign ctrl_o.fire = fire;

endmodule

// File: rtl/core/integer_to_radix_digits_unit.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits_unit
// Converts signed integers to their text in a configurable radix.
// ----------------------------------------------------------------------------
// Channels: in_i takes one signed value per transaction; out_o gives one
// character per transaction, most significant digit first, with a leading
// '-' for negatives and last set on the final character. cfg_i writes
// base_length (index 0), symbols_low (1) and symbols_high (2); it is always
// ready and must only be used while the unit is idle.
// A value is taken only while the sequencer sits at its accept step. With an
// invalid base the value is dropped and the unit is ready again next cycle.
// Sequence: each digit costs one divider pass, started by the divide step and
// collected by the wait step, which pushes the digit; each character then takes
// a stack read step and an emit step. The accept and sign steps come first.
// The output register lets the next transaction be prepared while a
// character waits; a stalled receiver simply holds the sequencer.
// Reset clears the config, value, sign and count registers to zero, the step
// counter to the accept step and the output valid; the stack needs no clearing.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_unit #(
  parameter int unsigned MAX_RADIX  = itrd_pkg::MAX_RADIX_DEF,
  parameter int unsigned VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itrd_cfg_if.sink   cfg_i,
  itrd_in_if.sink    in_i,
  itrd_out_if.source out_o
);

  import itrd_pkg::*;

  localparam int unsigned RADIX_W = $clog2(MAX_RADIX + 1);
  localparam int unsigned DIGIT_W = $clog2(MAX_RADIX);
  localparam int unsigned ADDR_W  = $clog2(VALUE_BITS);
  localparam int unsigned CNT_W   = $clog2(VALUE_BITS + 1);

  logic [LEN_W-1:0]      base_len_q;
  logic [SYM_WORD_W-1:0] sym_lo_q;
  logic [SYM_WORD_W-1:0] sym_hi_q;

  logic [VALUE_BITS-1:0] mag_q;
  logic                  neg_q;
  logic [CNT_W-1:0]      count_q;
  logic [CNT_W-1:0]      count_dec;

  logic                  out_valid_q;
  logic [CHAR_W-1:0]     char_q;
  logic                  last_q;
  logic                  out_free;

  logic [VALUE_BITS-1:0] raw;
  logic                  raw_neg;
  logic [VALUE_BITS-1:0] raw_mag;

  seq_status_t           status;
  seq_ctrl_t             ctrl;

  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] quotient;
  logic [RADIX_W-1:0]    remainder;

  logic                  push;
  logic                  pop;
  logic [DIGIT_W-1:0]    digit;
  logic [CHAR_W-1:0]     digit_char;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_len_q <= '0;
      sym_lo_q   <= '0;
      sym_hi_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BASE_LEN: base_len_q <= cfg_i.data[LEN_W-1:0];
        CFG_SYM_LO:   sym_lo_q   <= cfg_i.data;
        CFG_SYM_HI:   sym_hi_q   <= cfg_i.data;
        default:      ;
      endcase
    end
  end

  // input magnitude, most negative value wraps to its unsigned magnitude
  assign raw     = in_i.value[VALUE_BITS-1:0];
  assign raw_neg = raw[VALUE_BITS-1];
  assign raw_mag = raw_neg ? (~raw + VALUE_BITS'(1)) : raw;

  assign out_free  = !out_valid_q || out_o.ready;
  assign count_dec = count_q - CNT_W'(1);

  assign status.in_valid = in_i.valid;
  assign status.base_ok  = base_ok(base_len_q, sym_lo_q, sym_hi_q, LEN_W'(MAX_RADIX));
  assign status.out_free = out_free;
  assign status.neg      = neg_q;
  assign status.div_done = div_done;
  assign status.quot_nz  = (quotient != '0);
  assign status.count_nz = (count_q != '0);

  itrd_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign in_i.ready = (ctrl.op == UOP_ACCEPT);
  assign div_start  = ctrl.fire && (ctrl.op == UOP_DIV_GO);
  assign push       = ctrl.fire && (ctrl.op == UOP_DIV_WAIT);
  assign pop        = ctrl.fire && (ctrl.op == UOP_POP);

  itrd_divider #(
    .VALUE_BITS (VALUE_BITS),
    .RADIX_W    (RADIX_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (mag_q),
    .divisor_i   (RADIX_W'(base_len_q)),
    .done_o      (div_done),
    .quotient_o  (quotient),
    .remainder_o (remainder)
  );

  // digit stack, least significant digit pushed first
  itrd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (DIGIT_W'(remainder)),
    .re_i    (pop),
    .raddr_i (count_dec[ADDR_W-1:0]),
    .rdata_o (digit)
  );

  assign digit_char = symbol_at(sym_lo_q, sym_hi_q, 4'(digit));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q   <= '0;
      neg_q   <= 1'b0;
      count_q <= '0;
    end else if (ctrl.fire) begin
      case (ctrl.op)
        UOP_ACCEPT: begin
          mag_q   <= raw_mag;
          neg_q   <= raw_neg;
          count_q <= '0;
        end
        UOP_DIV_WAIT: begin
          mag_q   <= quotient;
          count_q <= count_q + CNT_W'(1);
        end
        UOP_POP: begin
          count_q <= count_dec;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.fire && ctrl.op == UOP_SIGN && neg_q) begin
      out_valid_q <= 1'b1;
    end else if (ctrl.fire && ctrl.op == UOP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.fire && ctrl.op == UOP_SIGN && neg_q) begin
      char_q <= CHAR_MINUS;
      last_q <= 1'b0;
    end else if (ctrl.fire && ctrl.op == UOP_EMIT) begin
      char_q <= digit_char;
      last_q <= (count_q == '0);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

endmodule

// File: rtl/core/itrd_checker.sv
// ----------------------------------------------------------------------------
// itrd_checker
// Port-level checks of the integer to radix digits unit, bound to the top.
// ----------------------------------------------------------------------------
module itrd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [itrd_pkg::CHAR_W-1:0] out_char_i,
  input logic                        out_last_i
);

  import itrd_pkg::*;

  // a stalled character holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i) && $stable(out_last_i))
    else $error("output transaction changed while stalled");

  // reset clears the output valid
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

  // no new value is taken while a non-final character is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready in the middle of a text");

  // the final character is never a minus sign
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> out_char_i != CHAR_MINUS)
    else $error("text ends in a minus sign");

  // a value is taken while a character waits only if that character is the final one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && out_valid_i |-> out_last_i)
    else $error("input accepted while a non-final character waits");

endmodule

bind integer_to_radix_digits_unit itrd_checker u_itrd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.character),
  .out_last_i  (out_o.last)
);
